>>> design/gcc_pkg.sv
// Shared constants and command codes for the greedy coin change block.
// Used by the top level and by its checker.
`default_nettype none

package gcc_pkg;

	localparam int MAX_COINS  = 16;
	localparam int VALUE_BITS = 16;
	localparam int AMT_BITS   = VALUE_BITS + 1;
	localparam int CNT_BITS   = 17;
	localparam int CFG_BITS   = 5;
	localparam int IDX_BITS   = $clog2(MAX_COINS);
	localparam int DCNT_BITS  = $clog2(AMT_BITS);

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_CHANGE = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;

endpackage

`default_nettype wire

>>> design/greedy_change_canonical_check_top.sv
// Greedy coin change and canonicity check: coin table, sequencer, serial divider.
// Depends on gcc_pkg for widths and command codes.
//
// channel  | handshake             | payload
// cmd      | cmd_valid / cmd_stall | command, slot, coin_value, amount
// res      | res_valid / res_stall | coin_total, unpayable, canonical, bad_amount, bad_coin
// cfg      | cfg_wen               | cfg_wdata (coins_in_use)
//
// A load or idle command goes straight to the done state. A change walks the coins
// from the top slot in use down (fetch, test, 17 divide steps, accumulate); the shared
// restoring divider, used by both commands, gives one quotient bit per cycle. A check runs
// one greedy walk per amount and one per coin below it, so its length follows the
// span of amounts tested. cmd_stall is high from an accepted item until its result
// is moved into the output register; a result waiting on res_stall does not block
// the next item. Reset clears the sequencer, coins_in_use and res_valid, not the table.
`default_nettype none

module greedy_change_canonical_check_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wen,
	input  wire logic [gcc_pkg::CFG_BITS-1:0]          cfg_wdata,
	input  wire logic                                  cmd_valid,
	output logic                                       cmd_stall,
	input  wire logic [1:0]                            command,
	input  wire logic [3:0]                            slot,
	input  wire logic [gcc_pkg::VALUE_BITS-1:0]        coin_value,
	input  wire logic [15:0]                           amount,
	output logic                                       res_valid,
	input  wire logic                                  res_stall,
	output logic [gcc_pkg::CNT_BITS-1:0]               coin_total,
	output logic                                       unpayable,
	output logic                                       canonical,
	output logic [gcc_pkg::AMT_BITS-1:0]               bad_amount,
	output logic [gcc_pkg::VALUE_BITS-1:0]             bad_coin
);

	localparam int VB = gcc_pkg::VALUE_BITS;
	localparam int AB = gcc_pkg::AMT_BITS;
	localparam int CB = gcc_pkg::CNT_BITS;
	localparam int KB = gcc_pkg::CFG_BITS;
	localparam int IB = gcc_pkg::IDX_BITS;
	localparam int DB = gcc_pkg::DCNT_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_G_LOOP,
		S_G_TEST,
		S_G_DIV,
		S_G_ACC,
		S_C_A,
		S_C_B,
		S_C_C,
		S_C_D,
		S_C_X,
		S_C_GX,
		S_C_J,
		S_C_JT,
		S_C_CMP,
		S_DONE
	} state_t;

	state_t              state_q;
	state_t              gret_q;
	logic [KB-1:0]       coins_q;
	logic [KB-1:0]       k;
	logic [KB-1:0]       gm1;
	logic [KB-1:0]       km1;
	logic [KB-1:0]       km2;
	logic [1:0]          cmd_q;
	logic [AB-1:0]       rem_q;
	logic [CB-1:0]       cnt_q;
	logic [CB-1:0]       gx_q;
	logic [KB-1:0]       gi_q;
	logic [KB-1:0]       j_q;
	logic [AB-1:0]       x_q;
	logic [AB-1:0]       end_q;
	logic [VB-1:0]       cj_q;
	logic                fail_q;
	logic [VB-1:0]       p_q;
	logic [AB-1:0]       qsh_q;
	logic [DB-1:0]       dcnt_q;
	logic [VB-1:0]       coin_q;
	logic [VB-1:0]       coin_mem [gcc_pkg::MAX_COINS];
	logic                rd_en;
	logic [IB-1:0]       rd_addr;
	logic [VB:0]         div_t;
	logic [VB:0]         div_d;
	logic                div_ge;
	logic [VB-1:0]       p_nxt;
	logic                accept;
	logic                res_valid_q;
	logic [CB-1:0]       coin_total_q;
	logic                unpayable_q;
	logic                canonical_q;
	logic [AB-1:0]       bad_amount_q;
	logic [VB-1:0]       bad_coin_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);

	assign k   = (coins_q > KB'(gcc_pkg::MAX_COINS)) ? KB'(gcc_pkg::MAX_COINS) : coins_q;
	assign gm1 = gi_q - KB'(1);
	assign km1 = k - KB'(1);
	assign km2 = k - KB'(2);

	// one restoring divide step
	assign div_t  = {p_q, qsh_q[AB-1]};
	assign div_d  = div_t - {1'b0, coin_q};
	assign div_ge = (div_t >= {1'b0, coin_q});
	assign p_nxt  = div_ge ? div_d[VB-1:0] : div_t[VB-1:0];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_G_LOOP: begin
				rd_en   = 1'b1;
				rd_addr = gm1[IB-1:0];
			end
			S_C_A: begin
				rd_en   = 1'b1;
				rd_addr = IB'(2);
			end
			S_C_B: begin
				rd_en   = 1'b1;
				rd_addr = km2[IB-1:0];
			end
			S_C_C: begin
				rd_en   = 1'b1;
				rd_addr = km1[IB-1:0];
			end
			S_C_J: begin
				rd_en   = 1'b1;
				rd_addr = j_q[IB-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && command == gcc_pkg::CMD_LOAD && 32'(slot) < gcc_pkg::MAX_COINS) begin
			coin_mem[slot] <= coin_value;
		end
		if (rd_en) begin
			coin_q <= coin_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coins_q <= '0;
		end else if (cfg_wen) begin
			coins_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gret_q       <= S_DONE;
			cmd_q        <= gcc_pkg::CMD_LOAD;
			rem_q        <= '0;
			cnt_q        <= '0;
			gx_q         <= '0;
			gi_q         <= '0;
			j_q          <= '0;
			x_q          <= '0;
			end_q        <= '0;
			cj_q         <= '0;
			fail_q       <= 1'b0;
			p_q          <= '0;
			qsh_q        <= '0;
			dcnt_q       <= '0;
			res_valid_q  <= 1'b0;
			coin_total_q <= '0;
			unpayable_q  <= 1'b0;
			canonical_q  <= 1'b0;
			bad_amount_q <= '0;
			bad_coin_q   <= '0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= command;
						rem_q  <= AB'(amount);
						cnt_q  <= '0;
						gi_q   <= k;
						gret_q <= S_DONE;
						fail_q <= 1'b0;
						unique case (command)
							gcc_pkg::CMD_CHANGE: state_q <= S_G_LOOP;
							gcc_pkg::CMD_CHECK:  state_q <= (k >= KB'(3)) ? S_C_A : S_DONE;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_G_LOOP: begin
					if (gi_q == '0 || rem_q == '0) begin
						state_q <= gret_q;
					end else begin
						gi_q    <= gm1;
						state_q <= S_G_TEST;
					end
				end
				S_G_TEST: begin
					if (coin_q == '0 || {1'b0, coin_q} > rem_q) begin
						state_q <= S_G_LOOP;
					end else begin
						p_q     <= '0;
						qsh_q   <= rem_q;
						dcnt_q  <= DB'(AB - 1);
						state_q <= S_G_DIV;
					end
				end
				S_G_DIV: begin
					p_q   <= p_nxt;
					qsh_q <= {qsh_q[AB-2:0], div_ge};
					if (dcnt_q == '0) begin
						state_q <= S_G_ACC;
					end else begin
						dcnt_q <= dcnt_q - DB'(1);
					end
				end
				S_G_ACC: begin
					cnt_q   <= cnt_q + CB'(qsh_q);
					rem_q   <= {1'b0, p_q};
					state_q <= S_G_LOOP;
				end
				S_C_A: begin
					state_q <= S_C_B;
				end
				S_C_B: begin
					x_q     <= {1'b0, coin_q} + AB'(2);
					state_q <= S_C_C;
				end
				S_C_C: begin
					end_q   <= {1'b0, coin_q};
					state_q <= S_C_D;
				end
				S_C_D: begin
					end_q   <= end_q + {1'b0, coin_q};
					state_q <= S_C_X;
				end
				S_C_X: begin
					if (x_q >= end_q) begin
						state_q <= S_DONE;
					end else begin
						rem_q   <= x_q;
						cnt_q   <= '0;
						gi_q    <= k;
						gret_q  <= S_C_GX;
						state_q <= S_G_LOOP;
					end
				end
				S_C_GX: begin
					gx_q    <= cnt_q;
					j_q     <= '0;
					state_q <= S_C_J;
				end
				S_C_J: begin
					if (j_q == k) begin
						x_q     <= x_q + AB'(1);
						state_q <= S_C_X;
					end else begin
						state_q <= S_C_JT;
					end
				end
				S_C_JT: begin
					cj_q <= coin_q;
					if ({1'b0, coin_q} < x_q) begin
						rem_q   <= x_q - {1'b0, coin_q};
						cnt_q   <= '0;
						gi_q    <= k;
						gret_q  <= S_C_CMP;
						state_q <= S_G_LOOP;
					end else begin
						j_q     <= j_q + KB'(1);
						state_q <= S_C_J;
					end
				end
				S_C_CMP: begin
					if ({1'b0, gx_q} > ({1'b0, cnt_q} + (CB + 1)'(1))) begin
						fail_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						j_q     <= j_q + KB'(1);
						state_q <= S_C_J;
					end
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q  <= 1'b1;
						coin_total_q <= (cmd_q == gcc_pkg::CMD_CHANGE) ? cnt_q : '0;
						unpayable_q  <= (cmd_q == gcc_pkg::CMD_CHANGE) && (rem_q != '0);
						canonical_q  <= (cmd_q == gcc_pkg::CMD_CHECK) && !fail_q;
						bad_amount_q <= (cmd_q == gcc_pkg::CMD_CHECK && fail_q) ? x_q : '0;
						bad_coin_q   <= (cmd_q == gcc_pkg::CMD_CHECK && fail_q) ? cj_q : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign coin_total = coin_total_q;
	assign unpayable  = unpayable_q;
	assign canonical  = canonical_q;
	assign bad_amount = bad_amount_q;
	assign bad_coin   = bad_coin_q;

endmodule

`default_nettype wire

>>> design/gcc_checker.sv
// Port-level checks for the greedy coin change block, bound to its top level.
// Depends on gcc_pkg for widths.
`default_nettype none

module gcc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cmd_valid,
	input wire logic                              cmd_stall,
	input wire logic                              res_valid,
	input wire logic                              res_stall,
	input wire logic [gcc_pkg::CNT_BITS-1:0]      coin_total,
	input wire logic                              unpayable,
	input wire logic                              canonical,
	input wire logic [gcc_pkg::AMT_BITS-1:0]      bad_amount,
	input wire logic [gcc_pkg::VALUE_BITS-1:0]    bad_coin
);

	// busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("cmd_stall low right after an accepted item");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(coin_total) && $stable(unpayable)
			&& $stable(canonical) && $stable(bad_amount) && $stable(bad_coin))
		else $error("stalled result changed");

	a_canon_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && canonical |-> bad_amount == '0 && bad_coin == '0
			&& coin_total == '0 && !unpayable)
		else $error("canonical result carries other fields");

	a_change_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (coin_total != '0 || unpayable) |-> !canonical && bad_amount == '0)
		else $error("change result mixed with check fields");

	a_counterexample: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bad_coin != '0 |-> bad_amount != '0 && !canonical)
		else $error("counterexample coin without amount");

endmodule

bind greedy_change_canonical_check_top gcc_checker u_gcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_valid),
	.cmd_stall  (cmd_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.coin_total (coin_total),
	.unpayable  (unpayable),
	.canonical  (canonical),
	.bad_amount (bad_amount),
	.bad_coin   (bad_coin)
);

`default_nettype wire
